// ===== src/dclf_pkg.sv =====
// Package for the channel linear fader: per-channel state record, controller
// states, controller/datapath command and status bundles, and fixed constants.
// No dependencies.
package dclf_pkg;

	// One channel's stored state. level is unsigned 8.16; step is signed
	// 16 fraction bits of level per tick.
	typedef struct packed {
		logic [7:0]  bright;
		logic        on;
		logic [23:0] level;
		logic [31:0] step;
		logic [7:0]  target;
	} chan_entry_t;

	localparam logic [7:0]  BRIGHT_RST     = 8'd255;
	localparam logic [7:0]  FRAME_RATE_RST = 8'd40;
	localparam logic [15:0] FADE_TIME_RST  = 16'd256;

	localparam chan_entry_t RESET_ENTRY = '{
		bright: BRIGHT_RST,
		on:     1'b0,
		level:  24'd0,
		step:   32'd0,
		target: 8'd0
	};

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FADE = 1'b1;

	// Iterations of the restoring divider, one quotient bit each.
	localparam logic [5:0] DIV_STEPS = 6'd32;
	localparam logic [31:0] STEP_MAX = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD_RD,
		ST_CMD_EVAL,
		ST_CMD_DIV,
		ST_CMD_EMIT,
		ST_TK_RD,
		ST_TK_UPD
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;
		logic read;
		logic eval;
		logic write;
		logic emit;
		logic idx_inc;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic req_tick;
		logic ch_oor;
		logic div_busy;
		logic out_free;
		logic tick_last;
	} dp_sts_t;

endpackage

// ===== src/dmx_channel_linear_fader_core.sv =====
// Top level of the per-channel linear light fader: controller, datapath and
// channel state memory. Depends on dclf_pkg, dclf_ctrl, dclf_dp, dclf_store.
//
// Usage:
// The input channel (in_valid/in_stall) carries either a set command for one
// channel (action = 0) or a render tick (action = 1). A transaction is taken
// only while the block is idle; in_stall is high while an item is in work.
// A set command gives one status result; a command for a channel at or above
// NUM_CHANNELS gives none and frees the input once the channel check fails.
// A tick gives NUM_CHANNELS level results, the final one with last set.
// A timed fade command loads its result once the restoring divider has formed
// the step; an instant or no-change command skips the divider. A tick reads,
// updates and loads its results one channel at a time, bound by the single read
// port of the channel memory. The next item can be taken once the last result is
// loaded; while a result is held by out_stall, the next one is not loaded. A new
// item may be accepted while the previous result still waits.
// Reset clears all channels (brightness 255, off, level 0) at once and loads
// frame_rate 40 and default_fade_time 256. The configuration port never stalls.
module dmx_channel_linear_fader_core #(
	parameter int unsigned NUM_CHANNELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [5:0]  channel,
	input  logic        turn_on,
	input  logic        has_brightness,
	input  logic [7:0]  brightness,
	input  logic        has_fade_time,
	input  logic [15:0] fade_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [5:0]  out_channel,
	output logic        on_flag,
	output logic [7:0]  remembered_level,
	output logic [7:0]  level,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dclf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	dclf_pkg::dp_cmd_t     cmd;
	dclf_pkg::dp_sts_t     sts;
	dclf_pkg::chan_entry_t mem_wdata, mem_rdata;
	logic                  mem_re, mem_we;
	logic [AW-1:0]         mem_addr;
	logic                  cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	dclf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dclf_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.AW           (AW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.channel          (channel),
		.turn_on          (turn_on),
		.has_brightness   (has_brightness),
		.brightness       (brightness),
		.has_fade_time    (has_fade_time),
		.fade_time        (fade_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.out_channel      (out_channel),
		.on_flag          (on_flag),
		.remembered_level (remembered_level),
		.level            (level),
		.last             (last),
		.mem_re           (mem_re),
		.mem_we           (mem_we),
		.mem_addr         (mem_addr),
		.mem_wdata        (mem_wdata),
		.mem_rdata        (mem_rdata)
	);

	dclf_store #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.AW           (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_re),
		.we     (mem_we),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

endmodule

// ===== src/dclf_store.sv =====
// Channel state memory for the linear fader: one record per channel with a
// registered read port and per-entry valid bits. Depends on dclf_pkg.
module dclf_store #(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned AW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  re,
	input  logic                  we,
	input  logic [AW-1:0]         addr,
	input  dclf_pkg::chan_entry_t wdata,
	output dclf_pkg::chan_entry_t rdata
);

	dclf_pkg::chan_entry_t mem_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	dclf_pkg::chan_entry_t rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rd_q     <= mem_q[addr];
			rd_vld_q <= vld_q[addr];
		end
	end

	// An entry never written reads as the reset record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[addr] <= 1'b1;
		end
	end

	assign rdata = rd_vld_q ? rd_q : dclf_pkg::RESET_ENTRY;

endmodule

// ===== src/dclf_ctrl.sv =====
// Controller for the linear fader: sequences command and tick transactions
// and issues commands to the datapath. Depends on dclf_pkg.
module dclf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dclf_pkg::dp_sts_t sts,
	output dclf_pkg::dp_cmd_t cmd
);

	dclf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dclf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dclf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.req_tick ? dclf_pkg::ST_TK_RD : dclf_pkg::ST_CMD_RD;
				end
			end
			dclf_pkg::ST_CMD_RD: begin
				state_d = sts.ch_oor ? dclf_pkg::ST_IDLE : dclf_pkg::ST_CMD_EVAL;
			end
			dclf_pkg::ST_CMD_EVAL: state_d = dclf_pkg::ST_CMD_DIV;
			dclf_pkg::ST_CMD_DIV: begin
				if (!sts.div_busy) begin
					state_d = dclf_pkg::ST_CMD_EMIT;
				end
			end
			dclf_pkg::ST_CMD_EMIT: begin
				if (sts.out_free) begin
					state_d = dclf_pkg::ST_IDLE;
				end
			end
			dclf_pkg::ST_TK_RD: state_d = dclf_pkg::ST_TK_UPD;
			dclf_pkg::ST_TK_UPD: begin
				if (sts.out_free) begin
					state_d = sts.tick_last ? dclf_pkg::ST_IDLE : dclf_pkg::ST_TK_RD;
				end
			end
			default: state_d = dclf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			dclf_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			dclf_pkg::ST_CMD_RD: cmd.read = !sts.ch_oor;
			dclf_pkg::ST_CMD_EVAL: cmd.eval = 1'b1;
			dclf_pkg::ST_CMD_DIV: cmd = '0;
			dclf_pkg::ST_CMD_EMIT: begin
				cmd.write = sts.out_free;
				cmd.emit  = sts.out_free;
			end
			dclf_pkg::ST_TK_RD: cmd.read = 1'b1;
			dclf_pkg::ST_TK_UPD: begin
				cmd.write   = sts.out_free;
				cmd.emit    = sts.out_free;
				cmd.idx_inc = sts.out_free && !sts.tick_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/dclf_dp.sv =====
// Datapath for the linear fader: configuration registers, input capture,
// command evaluation, iterative step divider, tick update and output register.
// Depends on dclf_pkg.
module dclf_dp #(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned AW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dclf_pkg::dp_cmd_t     cmd,
	output dclf_pkg::dp_sts_t     sts,
	input  logic                  cfg_we,
	input  logic [dclf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  action,
	input  logic [5:0]            channel,
	input  logic                  turn_on,
	input  logic                  has_brightness,
	input  logic [7:0]            brightness,
	input  logic                  has_fade_time,
	input  logic [15:0]           fade_time,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  kind,
	output logic [5:0]            out_channel,
	output logic                  on_flag,
	output logic [7:0]            remembered_level,
	output logic [7:0]            level,
	output logic                  last,
	output logic                  mem_re,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_addr,
	output dclf_pkg::chan_entry_t mem_wdata,
	input  dclf_pkg::chan_entry_t mem_rdata
);

	logic [7:0]  frame_rate_q;
	logic [15:0] def_time_q;

	logic        act_q, on_q, hasb_q;
	logic [5:0]  ch_q;
	logic [7:0]  bright_q;
	logic [15:0] time_q;
	logic [AW-1:0] idx_q;

	dclf_pkg::chan_entry_t upd_q, cmd_e, fin_e, tick_e;
	logic        need_div, need_div_q, neg_q;
	logic [23:0] tfx, mag;
	logic [24:0] diff;
	logic [7:0]  bright_n, rate_eff;
	logic [23:0] prod;

	logic [31:0] dvd_q;
	logic [23:0] rem_q, den_q;
	logic [5:0]  div_cnt_q;
	logic [24:0] rem_sh;
	logic        ge;
	logic [31:0] q_sat, step_div;

	logic        tick_last;
	logic [33:0] lv, tgt;
	logic        s_pos, s_neg;

	logic        out_valid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= dclf_pkg::FRAME_RATE_RST;
			def_time_q   <= dclf_pkg::FADE_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dclf_pkg::CFG_FRAME_RATE:   frame_rate_q <= cfg_data[7:0];
				dclf_pkg::CFG_DEFAULT_FADE: def_time_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input capture; the fade time is resolved against the default here.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= action;
			ch_q     <= channel;
			on_q     <= turn_on;
			hasb_q   <= has_brightness;
			bright_q <= brightness;
			time_q   <= has_fade_time ? fade_time : def_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.accept) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign tick_last = (idx_q == AW'(NUM_CHANNELS - 1));
	assign mem_addr  = act_q ? idx_q : ch_q[AW-1:0];
	assign mem_re    = cmd.read;
	assign mem_we    = cmd.write;

	// Command evaluation on the record just read.
	always_comb begin
		cmd_e    = mem_rdata;
		need_div = 1'b0;
		bright_n = hasb_q ? bright_q : mem_rdata.bright;
		tfx      = '0;
		if (on_q) begin
			cmd_e.bright = bright_n;
			cmd_e.target = bright_n;
			tfx          = {bright_n, 16'h0000};
			if (tfx != mem_rdata.level) begin
				if (time_q != 16'd0) begin
					need_div = 1'b1;
				end else begin
					cmd_e.level = tfx;
					cmd_e.step  = '0;
				end
				cmd_e.on = (bright_n != 8'd0);
			end
		end else if (mem_rdata.level != 24'd0) begin
			cmd_e.target = '0;
			if (time_q != 16'd0) begin
				need_div = 1'b1;
			end else begin
				cmd_e.level = '0;
				cmd_e.step  = '0;
			end
			cmd_e.on = 1'b0;
		end
	end

	assign diff     = {1'b0, tfx} - {1'b0, mem_rdata.level};
	assign mag      = diff[24] ? 24'(-diff) : diff[23:0];
	assign rate_eff = (frame_rate_q == 8'd0) ? 8'd1 : frame_rate_q;
	assign prod     = {8'h00, time_q} * {16'h0000, rate_eff};

	// Restoring divider on magnitudes, one quotient bit per cycle.
	assign rem_sh = {rem_q, dvd_q[31]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			upd_q      <= cmd_e;
			need_div_q <= need_div;
			neg_q      <= diff[24];
			dvd_q      <= {mag, 8'h00};
			rem_q      <= '0;
			den_q      <= prod;
		end else if (div_cnt_q != 6'd0) begin
			rem_q <= ge ? 24'(rem_sh - {1'b0, den_q}) : rem_sh[23:0];
			dvd_q <= {dvd_q[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.eval) begin
			div_cnt_q <= need_div ? dclf_pkg::DIV_STEPS : 6'd0;
		end else if (div_cnt_q != 6'd0) begin
			div_cnt_q <= div_cnt_q - 6'd1;
		end
	end

	assign q_sat    = dvd_q[31] ? dclf_pkg::STEP_MAX : dvd_q;
	assign step_div = neg_q ? (32'd0 - q_sat) : q_sat;

	always_comb begin
		fin_e = upd_q;
		if (need_div_q) begin
			fin_e.step = step_div;
		end
	end

	// Tick update: move by the step and clamp at the target.
	assign s_neg = mem_rdata.step[31];
	assign s_pos = !s_neg && (mem_rdata.step != 32'd0);
	assign lv    = {10'd0, mem_rdata.level} + {{2{mem_rdata.step[31]}}, mem_rdata.step};
	assign tgt   = {10'd0, mem_rdata.target, 16'h0000};

	always_comb begin
		tick_e = mem_rdata;
		if (s_pos) begin
			if ($signed(lv) >= $signed(tgt)) begin
				tick_e.level = tgt[23:0];
				tick_e.step  = '0;
			end else begin
				tick_e.level = lv[23:0];
			end
		end else if (s_neg) begin
			if ($signed(lv) <= $signed(tgt)) begin
				tick_e.level = tgt[23:0];
				tick_e.step  = '0;
			end else begin
				tick_e.level = lv[23:0];
			end
		end
	end

	assign mem_wdata = act_q ? tick_e : fin_e;

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind             <= act_q;
			out_channel      <= act_q ? 6'(idx_q) : ch_q;
			on_flag          <= mem_wdata.on;
			remembered_level <= mem_wdata.bright;
			level            <= mem_wdata.level[23:16];
			last             <= act_q ? tick_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.req_tick  = action;
	assign sts.ch_oor    = ({1'b0, ch_q} >= 7'(NUM_CHANNELS));
	assign sts.div_busy  = (div_cnt_q != 6'd0);
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.tick_last = tick_last;

endmodule
